/* rtl/lsvf_pkg.sv */
// ----------------------------------------------------------------------------
// lsvf_pkg
// Types and constants for the level-set to volume-fraction pipeline.
// ----------------------------------------------------------------------------
package lsvf_pkg;

  localparam int FRAC_BITS      = 24;
  localparam int FLAT_THR_DEF   = 2;
  localparam int FLOOR_W        = 31;
  localparam logic [FLOOR_W-1:0] FLOOR_RST = 31'd17;
  localparam int VF_W           = FRAC_BITS + 1;
  localparam int GRAD_W         = 32;
  localparam int VTX_W          = 34;
  localparam int NUM_W          = 101;

  localparam logic [1:0] MODE_FLAT = 2'd0;
  localparam logic [1:0] MODE_LIN  = 2'd1;
  localparam logic [1:0] MODE_QUAD = 2'd2;
  localparam logic [1:0] MODE_CUBE = 2'd3;

  typedef struct packed {
    logic signed [31:0] phi;
    logic signed [31:0] grad_x1;
    logic signed [31:0] grad_x2;
    logic signed [31:0] grad_x3;
  } in_t;

  typedef struct packed {
    logic [VF_W-1:0] volume_fraction;
    logic            status;
  } out_t;

  typedef struct packed {
    logic       valid;
    logic       status;
    logic       flat_half;
    logic [1:0] mode;
  } ctl_t;

endpackage

/* rtl/level_set_to_volume_fraction_neg_unit.sv */
// Pipeline: 8 datapath stages plus one restoring divide step per fraction
//   bit, 24 stages, from request accept to result valid.
// Throughput: one request per cycle; the whole pipeline holds while the
//   result at the output is stalled.
// Reset: synchronous active-low rst_n clears all valid bits and sets
//   gradient_floor to 17.
// ----------------------------------------------------------------------------
// level_set_to_volume_fraction_neg_unit
// Converts a non-positive level set and its gradient into a cell volume
// fraction using the cubic, quadratic or linear formula or the flat case.
// ----------------------------------------------------------------------------
module level_set_to_volume_fraction_neg_unit import lsvf_pkg::*; #(
  parameter int FLAT_THRESHOLD = FLAT_THR_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [FLOOR_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_t               out_data
);

  logic adv;
  logic [FLOOR_W-1:0] floor_r;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= FLOOR_RST;
    end else if (cfg_wr_en) begin
      floor_r <= cfg_wr_data;
    end
  end

  // stage 1: abs and sort
  logic [GRAD_W-1:0] g1, g2, g3, mx, mn;
  logic [GRAD_W+1:0] gsum;
  logic              flat_half_nxt;

  assign g1 = in_data.grad_x1[31] ? GRAD_W'(-in_data.grad_x1) : GRAD_W'(in_data.grad_x1);
  assign g2 = in_data.grad_x2[31] ? GRAD_W'(-in_data.grad_x2) : GRAD_W'(in_data.grad_x2);
  assign g3 = in_data.grad_x3[31] ? GRAD_W'(-in_data.grad_x3) : GRAD_W'(in_data.grad_x3);

  always_comb begin
    mx = (g1 > g2) ? g1 : g2;
    if (g3 > mx) mx = g3;
    mn = (g1 < g2) ? g1 : g2;
    if (g3 < mn) mn = g3;
  end

  assign gsum = {2'b00, g1} + {2'b00, g2} + {2'b00, g3};
  assign flat_half_nxt = !($signed({in_data.phi[31], in_data.phi})
                           <= -$signed(33'(FLAT_THRESHOLD)));

  logic                    s1_v_r, s1_st_r, s1_fh_r;
  logic signed [31:0]      s1_phi_r;
  logic [GRAD_W-1:0]       s1_xi_r, s1_eta_r, s1_zeta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_st_r   <= !in_data.phi[31] && (in_data.phi != '0);
      s1_fh_r   <= flat_half_nxt;
      s1_phi_r  <= in_data.phi;
      s1_xi_r   <= mx;
      s1_zeta_r <= mn;
      s1_eta_r  <= GRAD_W'(gsum - {2'b00, mx} - {2'b00, mn});
    end
  end

  // stage 2: vertices and mode
  logic signed [35:0] p2, ea, eb, ec;
  logic signed [35:0] sa, sb, sc, sd, se;
  logic [1:0]         mode_nxt;

  assign p2 = 36'(s1_phi_r) <<< 1;
  assign ea = $signed({4'b0, s1_xi_r});
  assign eb = $signed({4'b0, s1_eta_r});
  assign ec = $signed({4'b0, s1_zeta_r});
  assign sa = p2 + ea + eb + ec;
  assign sb = p2 + ea + eb - ec;
  assign sc = p2 + ea - eb + ec;
  assign sd = p2 - ea + eb + ec;
  assign se = p2 + ea - eb - ec;

  always_comb begin
    if (s1_xi_r <= {1'b0, floor_r}) mode_nxt = MODE_FLAT;
    else if (s1_eta_r <= {1'b0, floor_r}) mode_nxt = MODE_LIN;
    else if (s1_zeta_r <= {1'b0, floor_r}) mode_nxt = MODE_QUAD;
    else mode_nxt = MODE_CUBE;
  end

  ctl_t             s2_ctl_r;
  logic [VTX_W-1:0] s2_va_r, s2_vb_r, s2_vc_r, s2_vd_r, s2_ve_r;
  logic [GRAD_W-1:0] s2_xi_r, s2_eta_r, s2_zeta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r.valid <= 1'b0;
    end else if (adv) begin
      s2_ctl_r.valid <= s1_v_r;
    end
    if (adv) begin
      s2_ctl_r.status    <= s1_st_r;
      s2_ctl_r.flat_half <= s1_fh_r;
      s2_ctl_r.mode      <= mode_nxt;
      s2_va_r   <= (sa > 0) ? VTX_W'(sa) : '0;
      s2_vb_r   <= (sb > 0) ? VTX_W'(sb) : '0;
      s2_vc_r   <= (sc > 0) ? VTX_W'(sc) : '0;
      s2_vd_r   <= (sd > 0) ? VTX_W'(sd) : '0;
      s2_ve_r   <= (se > 0) ? VTX_W'(se) : '0;
      s2_xi_r   <= s1_xi_r;
      s2_eta_r  <= s1_eta_r;
      s2_zeta_r <= s1_zeta_r;
    end
  end

  // stage 3: squares and xi*eta
  ctl_t               s3_ctl_r;
  logic [VTX_W-1:0]   s3_va_r, s3_vb_r, s3_vc_r, s3_vd_r, s3_ve_r;
  logic [2*VTX_W-1:0] s3_qa_r, s3_qb_r, s3_qc_r, s3_qd_r, s3_qe_r;
  logic [63:0]        s3_xe_r;
  logic [GRAD_W-1:0]  s3_xi_r, s3_zeta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r.valid <= 1'b0;
    end else if (adv) begin
      s3_ctl_r.valid <= s2_ctl_r.valid;
    end
    if (adv) begin
      s3_ctl_r.status    <= s2_ctl_r.status;
      s3_ctl_r.flat_half <= s2_ctl_r.flat_half;
      s3_ctl_r.mode      <= s2_ctl_r.mode;
      s3_va_r <= s2_va_r;
      s3_vb_r <= s2_vb_r;
      s3_vc_r <= s2_vc_r;
      s3_vd_r <= s2_vd_r;
      s3_ve_r <= s2_ve_r;
      s3_qa_r <= {{VTX_W{1'b0}}, s2_va_r} * {{VTX_W{1'b0}}, s2_va_r};
      s3_qb_r <= {{VTX_W{1'b0}}, s2_vb_r} * {{VTX_W{1'b0}}, s2_vb_r};
      s3_qc_r <= {{VTX_W{1'b0}}, s2_vc_r} * {{VTX_W{1'b0}}, s2_vc_r};
      s3_qd_r <= {{VTX_W{1'b0}}, s2_vd_r} * {{VTX_W{1'b0}}, s2_vd_r};
      s3_qe_r <= {{VTX_W{1'b0}}, s2_ve_r} * {{VTX_W{1'b0}}, s2_ve_r};
      s3_xe_r <= {32'b0, s2_xi_r} * {32'b0, s2_eta_r};
      s3_xi_r   <= s2_xi_r;
      s3_zeta_r <= s2_zeta_r;
    end
  end

  // stage 4: partial products for cubes and denominator
  localparam int PP_W = 2 * VTX_W;

  ctl_t              s4_ctl_r;
  logic [PP_W-1:0]   s4_ha_r, s4_hb_r, s4_hc_r, s4_hd_r, s4_he_r;
  logic [PP_W-1:0]   s4_la_r, s4_lb_r, s4_lc_r, s4_ld_r, s4_le_r;
  logic [63:0]       s4_dh_r, s4_dl_r, s4_xe_r;
  logic [2*VTX_W-1:0] s4_qa_r, s4_qc_r;
  logic [VTX_W-1:0]  s4_va_r;
  logic [GRAD_W-1:0] s4_xi_r;

  function automatic logic [PP_W-1:0] mul_v(input logic [VTX_W-1:0] a,
                                            input logic [VTX_W-1:0] b);
    mul_v = {{VTX_W{1'b0}}, a} * {{VTX_W{1'b0}}, b};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ctl_r.valid <= 1'b0;
    end else if (adv) begin
      s4_ctl_r.valid <= s3_ctl_r.valid;
    end
    if (adv) begin
      s4_ctl_r.status    <= s3_ctl_r.status;
      s4_ctl_r.flat_half <= s3_ctl_r.flat_half;
      s4_ctl_r.mode      <= s3_ctl_r.mode;
      s4_ha_r <= mul_v(s3_qa_r[PP_W-1:VTX_W], s3_va_r);
      s4_hb_r <= mul_v(s3_qb_r[PP_W-1:VTX_W], s3_vb_r);
      s4_hc_r <= mul_v(s3_qc_r[PP_W-1:VTX_W], s3_vc_r);
      s4_hd_r <= mul_v(s3_qd_r[PP_W-1:VTX_W], s3_vd_r);
      s4_he_r <= mul_v(s3_qe_r[PP_W-1:VTX_W], s3_ve_r);
      s4_la_r <= mul_v(s3_qa_r[VTX_W-1:0], s3_va_r);
      s4_lb_r <= mul_v(s3_qb_r[VTX_W-1:0], s3_vb_r);
      s4_lc_r <= mul_v(s3_qc_r[VTX_W-1:0], s3_vc_r);
      s4_ld_r <= mul_v(s3_qd_r[VTX_W-1:0], s3_vd_r);
      s4_le_r <= mul_v(s3_qe_r[VTX_W-1:0], s3_ve_r);
      s4_dh_r <= {32'b0, s3_xe_r[63:32]} * {32'b0, s3_zeta_r};
      s4_dl_r <= {32'b0, s3_xe_r[31:0]} * {32'b0, s3_zeta_r};
      s4_xe_r <= s3_xe_r;
      s4_qa_r <= s3_qa_r;
      s4_qc_r <= s3_qc_r;
      s4_va_r <= s3_va_r;
      s4_xi_r <= s3_xi_r;
    end
  end

  // stage 5: assemble cubes and xi*eta*zeta
  function automatic logic [NUM_W-1:0] join_pp(input logic [PP_W-1:0] h,
                                               input logic [PP_W-1:0] l);
    join_pp = (NUM_W'(h) << VTX_W) + NUM_W'(l);
  endfunction

  ctl_t              s5_ctl_r;
  logic [NUM_W-1:0]  s5_ca_r, s5_cb_r, s5_cc_r, s5_cd_r, s5_ce_r;
  logic [95:0]       s5_d3_r;
  logic [63:0]       s5_xe_r;
  logic [2*VTX_W-1:0] s5_qa_r, s5_qc_r;
  logic [VTX_W-1:0]  s5_va_r;
  logic [GRAD_W-1:0] s5_xi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_ctl_r.valid <= 1'b0;
    end else if (adv) begin
      s5_ctl_r.valid <= s4_ctl_r.valid;
    end
    if (adv) begin
      s5_ctl_r.status    <= s4_ctl_r.status;
      s5_ctl_r.flat_half <= s4_ctl_r.flat_half;
      s5_ctl_r.mode      <= s4_ctl_r.mode;
      s5_ca_r <= join_pp(s4_ha_r, s4_la_r);
      s5_cb_r <= join_pp(s4_hb_r, s4_lb_r);
      s5_cc_r <= join_pp(s4_hc_r, s4_lc_r);
      s5_cd_r <= join_pp(s4_hd_r, s4_ld_r);
      s5_ce_r <= join_pp(s4_he_r, s4_le_r);
      s5_d3_r <= {s4_dh_r, 32'b0} + {32'b0, s4_dl_r};
      s5_xe_r <= s4_xe_r;
      s5_qa_r <= s4_qa_r;
      s5_qc_r <= s4_qc_r;
      s5_va_r <= s4_va_r;
      s5_xi_r <= s4_xi_r;
    end
  end

  // stage 6: select numerator and denominator
  logic [NUM_W-1:0] pos_nxt, neg_nxt, den_nxt;

  always_comb begin
    case (s5_ctl_r.mode)
      MODE_CUBE: begin
        pos_nxt = s5_ca_r + s5_ce_r;
        neg_nxt = s5_cb_r + s5_cc_r + s5_cd_r;
        den_nxt = (NUM_W'(s5_d3_r) << 5) + (NUM_W'(s5_d3_r) << 4);
      end
      MODE_QUAD: begin
        pos_nxt = NUM_W'(s5_qa_r);
        neg_nxt = NUM_W'(s5_qc_r);
        den_nxt = NUM_W'(s5_xe_r) << 3;
      end
      MODE_LIN: begin
        pos_nxt = NUM_W'(s5_va_r);
        neg_nxt = '0;
        den_nxt = NUM_W'(s5_xi_r) << 1;
      end
      default: begin
        pos_nxt = '0;
        neg_nxt = '0;
        den_nxt = NUM_W'(1);
      end
    endcase
  end

  ctl_t             s6_ctl_r;
  logic [NUM_W-1:0] s6_pos_r, s6_neg_r, s6_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_ctl_r.valid <= 1'b0;
    end else if (adv) begin
      s6_ctl_r.valid <= s5_ctl_r.valid;
    end
    if (adv) begin
      s6_ctl_r.status    <= s5_ctl_r.status;
      s6_ctl_r.flat_half <= s5_ctl_r.flat_half;
      s6_ctl_r.mode      <= s5_ctl_r.mode;
      s6_pos_r <= pos_nxt;
      s6_neg_r <= neg_nxt;
      s6_den_r <= den_nxt;
    end
  end

  lsvf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .ctl       (s6_ctl_r),
    .pos       (s6_pos_r),
    .neg       (s6_neg_r),
    .den       (s6_den_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.volume_fraction == '0)
    else $error("positive level set with nonzero volume");

  a_vf_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.volume_fraction <= (VF_W'(1) << FRAC_BITS))
    else $error("volume fraction above one");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("valid after reset");
`endif

endmodule

/* rtl/lsvf_div.sv */
// ----------------------------------------------------------------------------
// lsvf_div
// Saturating fractional divider, one restoring step per pipeline stage.
// ----------------------------------------------------------------------------
module lsvf_div import lsvf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  ctl_t             ctl,
  input  logic [NUM_W-1:0] pos,
  input  logic [NUM_W-1:0] neg,
  input  logic [NUM_W-1:0] den,
  output logic             out_valid,
  output out_t             out_data
);

  localparam logic [VF_W-1:0] VF_ONE  = VF_W'(1) << FRAC_BITS;
  localparam logic [VF_W-1:0] VF_HALF = VF_W'(1) << (FRAC_BITS - 1);

  logic             a_valid_r, a_fix_r, a_status_r;
  logic [VF_W-1:0]  a_fval_r;
  logic [NUM_W-1:0] a_rem_r, a_den_r;

  logic                 v_r    [0:FRAC_BITS];
  logic                 fix_r  [0:FRAC_BITS];
  logic                 st_r   [0:FRAC_BITS];
  logic [VF_W-1:0]      fval_r [0:FRAC_BITS];
  logic [NUM_W-1:0]     rem_r  [0:FRAC_BITS];
  logic [NUM_W-1:0]     den_r  [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] q_r    [0:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_status_r <= ctl.status;
      a_fix_r    <= ctl.status || (ctl.mode == MODE_FLAT) || (neg >= pos);
      a_fval_r   <= (!ctl.status && ctl.mode == MODE_FLAT && ctl.flat_half) ? VF_HALF : '0;
      a_rem_r    <= pos - neg;
      a_den_r    <= den;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0]   <= a_status_r;
      fix_r[0]  <= a_fix_r || (a_rem_r >= a_den_r);
      fval_r[0] <= a_fix_r ? a_fval_r : VF_ONE;
      rem_r[0]  <= a_rem_r;
      den_r[0]  <= a_den_r;
      q_r[0]    <= '0;
    end
  end

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
    logic [NUM_W-1:0] shl;
    logic             ge;

    assign shl = {rem_r[k][NUM_W-2:0], 1'b0};
    assign ge  = (shl >= den_r[k]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k+1]   <= st_r[k];
        fix_r[k+1]  <= fix_r[k];
        fval_r[k+1] <= fval_r[k];
        den_r[k+1]  <= den_r[k];
        rem_r[k+1]  <= ge ? (shl - den_r[k]) : shl;
        q_r[k+1]    <= {q_r[k][FRAC_BITS-2:0], ge};
      end
    end
  end

  assign out_valid                = v_r[FRAC_BITS];
  assign out_data.volume_fraction = fix_r[FRAC_BITS] ? fval_r[FRAC_BITS]
                                                     : {1'b0, q_r[FRAC_BITS]};
  assign out_data.status          = st_r[FRAC_BITS];

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the level-set to volume-fraction unit: directed
// table of corner cells, then random cells across all formula regimes and
// several gradient floors, with random gaps on requests and result stalls.
// ----------------------------------------------------------------------------
module tb import lsvf_pkg::*; ();

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [FLOOR_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  level_set_to_volume_fraction_neg_unit i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  typedef struct {
    in_t  req;
    logic fixed;
    out_t vf;
  } row_t;

  logic [FLOOR_W-1:0] grad_floor;
  out_t expected_vf[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  localparam int WATCHDOG = 5000;

  function automatic logic [255:0] cube(logic [255:0] v);
    return v * v * v;
  endfunction

  function automatic logic [255:0] quot(logic [255:0] pos, logic [255:0] neg,
                                        logic [255:0] den);
    logic [255:0] q;
    if (neg >= pos) return 0;
    if (pos - neg >= den) return 256'(1) << FRAC_BITS;
    q = ((pos - neg) << FRAC_BITS) / den;
    return q;
  endfunction

  function automatic out_t volume_of(in_t c);
    out_t r;
    logic signed [63:0] phi, v[5];
    logic [63:0] g[3], t, xi, eta, zeta;
    logic [255:0] vc[5], q;
    r = '0;
    phi = 64'(c.phi);
    if (phi > 0) begin
      r.status = 1'b1;
      return r;
    end
    g[0] = c.grad_x1 < 0 ? -64'(c.grad_x1) : 64'(c.grad_x1);
    g[1] = c.grad_x2 < 0 ? -64'(c.grad_x2) : 64'(c.grad_x2);
    g[2] = c.grad_x3 < 0 ? -64'(c.grad_x3) : 64'(c.grad_x3);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2 - i; j++)
        if (g[j] < g[j+1]) begin
          t = g[j]; g[j] = g[j+1]; g[j+1] = t;
        end
    xi = g[0]; eta = g[1]; zeta = g[2];
    v[0] = 2*phi + xi + eta + zeta;
    v[1] = 2*phi + xi + eta - zeta;
    v[2] = 2*phi + xi - eta + zeta;
    v[3] = 2*phi - xi + eta + zeta;
    v[4] = 2*phi + xi - eta - zeta;
    for (int i = 0; i < 5; i++) vc[i] = v[i] > 0 ? 256'(v[i]) : 256'(0);
    if (xi > grad_floor) begin
      if (eta > grad_floor) begin
        if (zeta > grad_floor)
          q = quot(cube(vc[0]) + cube(vc[4]), cube(vc[1]) + cube(vc[2]) + cube(vc[3]),
                   256'(xi) * eta * zeta * 48);
        else
          q = quot(vc[0] * vc[0], vc[2] * vc[2], 256'(xi) * eta * 8);
      end else begin
        q = quot(vc[0], 0, 256'(xi) * 2);
      end
    end else begin
      q = phi <= -64'(FLAT_THR_DEF) ? 0 : 256'(1) << (FRAC_BITS - 1);
    end
    r.volume_fraction = q[VF_W-1:0];
    return r;
  endfunction

  function automatic logic signed [31:0] rnd_grad();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 40) - 20;
      1: return $signed($urandom);
      2: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  function automatic in_t rnd_cell();
    in_t c;
    c.grad_x1 = rnd_grad();
    c.grad_x2 = rnd_grad();
    c.grad_x3 = rnd_grad();
    case ($urandom_range(0, 7))
      0: c.phi = $signed($urandom);
      1: c.phi = -$signed($urandom_range(0, 4));
      2: c.phi = $signed($urandom_range(1, 32'h7fff_ffff));
      default: c.phi = -$signed($urandom_range(0, 32'h0300_0000));
    endcase
    return c;
  endfunction

  function automatic int gap();
    return $urandom_range(0, 9) < 7 ? 0 : ($urandom_range(0, 9) < 8 ?
           $urandom_range(1, 3) : $urandom_range(10, 60));
  endfunction

  task automatic drive(in_t c, out_t e);
    int n;
    n = gap();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    expected_vf.push_back(e);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send(in_t c);
    drive(c, volume_of(c));
  endtask

  task automatic send_fixed(in_t c, out_t r);
    drive(c, r);
  endtask

  task automatic drain_and_write(logic [FLOOR_W-1:0] v);
    in_valid <= 1'b0;
    while (expected_vf.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    grad_floor  = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (stall_left == 0 && $urandom_range(0, 9) >= 6)
      stall_left = $urandom_range(0, 19) < 19 ? $urandom_range(1, 3) : $urandom_range(10, 60);
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left = stall_left - 1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_vf.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        out_t e;
        e = expected_vf.pop_front();
        if (out_data.volume_fraction !== e.volume_fraction || out_data.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected vf=%h st=%b, got vf=%h st=%b",
                     e.volume_fraction, e.status, out_data.volume_fraction, out_data.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  localparam logic signed [31:0] ONE = 32'sh0100_0000;
  row_t rows[$];
  logic [FLOOR_W-1:0] floors[5] = '{31'd0, 31'h7fff_ffff, 31'd17, 31'h0010_0000, 31'd1};

  initial begin
    grad_floor = FLOOR_RST;
    rows = '{
      '{'{32'sd1, ONE, ONE, ONE}, 1'b1, '{25'd0, 1'b1}},
      '{'{32'sh7fff_ffff, 0, 0, 0}, 1'b1, '{25'd0, 1'b1}},
      '{'{32'sd0, 0, 0, 0}, 1'b1, '{25'h80_0000, 1'b0}},
      '{'{-32'sd1, 0, 0, 0}, 1'b1, '{25'h80_0000, 1'b0}},
      '{'{-32'sd2, 0, 0, 0}, 1'b1, '{25'd0, 1'b0}},
      '{'{32'sh8000_0000, 5, -5, 17}, 1'b1, '{25'd0, 1'b0}},
      '{'{32'sd0, ONE, 0, 0}, 1'b1, '{25'h80_0000, 1'b0}},
      '{'{32'sd0, 0, -ONE, 0}, 1'b0, '0},
      '{'{32'sd0, ONE, ONE, 0}, 1'b0, '0},
      '{'{32'sd0, ONE, -ONE, ONE}, 1'b0, '0},
      '{'{-32'sh0080_0000, ONE, 32'sh0040_0000, 32'sh0020_0000}, 1'b0, '0},
      '{'{32'sh8000_0000, ONE, ONE, ONE}, 1'b1, '{25'd0, 1'b0}},
      '{'{-32'sd1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 1'b0, '0},
      '{'{-32'sd1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd18}, 1'b0, '0},
      '{'{32'sd0, 32'sd18, 32'sd18, 32'sd18}, 1'b0, '0},
      '{'{-32'sd9, 32'sd18, 32'sd18, 32'sd18}, 1'b0, '0},
      '{'{32'sd0, 32'sd17, 32'sd18, -32'sd17}, 1'b0, '0},
      '{'{32'sh7fff_ffff, -1, -1, -1}, 1'b1, '{25'd0, 1'b1}},
      '{'{32'sd0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff}, 1'b0, '0}
    };
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (rows[i]) begin
      if (rows[i].fixed) send_fixed(rows[i].req, rows[i].vf);
      else send(rows[i].req);
    end
    foreach (floors[k]) begin
      drain_and_write(floors[k]);
      for (int n = 0; n < 240; n++) send(rnd_cell());
    end
    in_valid <= 1'b0;
    while (expected_vf.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

/* level_set_to_volume_fraction_neg_unit.f */
rtl/lsvf_pkg.sv
rtl/lsvf_div.sv
rtl/level_set_to_volume_fraction_neg_unit.sv
test/tb.sv
